[hw/rtl/ids_pkg.sv]
// shared types, constants and the fnv-1a byte step for the image difference statistics block
// no dependencies; used by every module under hw/rtl
`default_nettype none

package ids_pkg;

	localparam int PIXEL_COUNT_BITS = 24;
	localparam int COUNT_W = 25;
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1) << PIXEL_COUNT_BITS;

	localparam int SSE_W = 42;
	localparam logic [SSE_W-1:0] SSE_MAX = {SSE_W{1'b1}};
	localparam int PIX_SSE_W = 18;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_TOLERANCE = 2'd0;
	localparam logic [1:0] REG_FRACTION = 2'd1;
	localparam logic [1:0] REG_RMSE = 2'd2;

	typedef struct packed {
		logic [31:0] actual_pixel;
		logic [31:0] baseline_pixel;
		logic        last_pixel;
	} pix_t;

	typedef struct packed {
		logic               passed;
		logic [COUNT_W-1:0] changed_count;
		logic [COUNT_W-1:0] total_count;
		logic [7:0]         largest_delta;
		logic [SSE_W-1:0]   squared_error_sum;
		logic [63:0]        actual_digest;
		logic [63:0]        baseline_digest;
	} res_t;

	typedef struct packed {
		logic [7:0]  tolerance;
		logic [16:0] fraction;
		logic [15:0] rmse;
	} cfg_t;

	// classified pixel pair as it waits in the queue
	typedef struct packed {
		logic [31:0]          actual;
		logic [31:0]          baseline;
		logic                 last;
		logic                 changed;
		logic [7:0]           pix_max;
		logic [PIX_SSE_W-1:0] pix_sse;
	} cls_t;

	// image totals handed from the accumulator to the result unit
	typedef struct packed {
		logic [COUNT_W-1:0] changed_count;
		logic [COUNT_W-1:0] total_count;
		logic [7:0]         largest_delta;
		logic [SSE_W-1:0]   sse;
		logic [63:0]        actual_digest;
		logic [63:0]        baseline_digest;
	} snap_t;

	// one fnv-1a step; prime is 2^40 + 0x1b3, 0x1b3 = bits 8,7,5,4,1,0
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v >= COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/image_diff_statistics_top.sv]
// a final pixel passes the queue and the ids_back hash, then ids_final states mul, prod, cmp
// and the result register; throughput is set by the byte-serial fnv-1a hash step in ids_back
// a 2-entry queue lets pixels arrive while the hash runs; the result register lets the next
// image stream in while a result waits to be taken
// reset: arst_n clears the limit registers, queue and handshakes; hashes restart at the fnv offset basis
// top level: apb register file and the front end, queue, accumulator and result unit
`default_nettype none

module image_diff_statistics_top (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         pix_valid,
	output logic                        pix_stall,
	input  wire ids_pkg::pix_t          pix,
	output logic                        res_valid,
	input  wire                         res_stall,
	output ids_pkg::res_t               res,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [ids_pkg::ADDR_W-1:0]   paddr,
	input  wire [31:0]                  pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	ids_pkg::cfg_t  cfg_q;
	logic [1:0]     reg_idx;
	logic           wr_en;

	logic           push;
	ids_pkg::cls_t  entry;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	ids_pkg::cls_t  q_head;
	logic           snap_valid;
	ids_pkg::snap_t snap;
	logic           fin_ready;

	assign pready = 1'b1;
	assign reg_idx = paddr[ids_pkg::ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				ids_pkg::REG_TOLERANCE: cfg_q.tolerance <= pwdata[7:0];
				ids_pkg::REG_FRACTION:  cfg_q.fraction <= pwdata[16:0];
				ids_pkg::REG_RMSE:      cfg_q.rmse <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ids_pkg::REG_TOLERANCE: prdata = {24'd0, cfg_q.tolerance};
			ids_pkg::REG_FRACTION:  prdata = {15'd0, cfg_q.fraction};
			ids_pkg::REG_RMSE:      prdata = {16'd0, cfg_q.rmse};
			default:                prdata = '0;
		endcase
	end

	ids_front u_front (
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.tolerance (cfg_q.tolerance),
		.q_full    (q_full),
		.push      (push),
		.entry     (entry)
	);

	ids_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	ids_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.snap_valid (snap_valid),
		.snap       (snap),
		.fin_ready  (fin_ready)
	);

	ids_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap       (snap),
		.fin_ready  (fin_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_stall  (res_stall)
	);

endmodule

`default_nettype wire

[hw/rtl/ids_front.sv]
// front end: accepts pixel pairs and classifies them (channel deltas, change flag, squares)
// depends on ids_pkg
`default_nettype none

module ids_front (
	input  wire ids_pkg::pix_t pix,
	input  wire                pix_valid,
	output logic               pix_stall,
	input  wire [7:0]          tolerance,
	input  wire                q_full,
	output logic               push,
	output ids_pkg::cls_t      entry
);

	logic [7:0]                    a_ch [4];
	logic [7:0]                    b_ch [4];
	logic [7:0]                    d_ch [4];
	logic [15:0]                   sq_ch [4];
	logic [ids_pkg::PIX_SSE_W-1:0] sse_sum;
	logic [7:0]                    max_d;
	logic                          chg;

	always_comb begin
		sse_sum = '0;
		max_d = '0;
		chg = 1'b0;
		for (int c = 0; c < 4; c++) begin
			a_ch[c] = pix.actual_pixel[8*c +: 8];
			b_ch[c] = pix.baseline_pixel[8*c +: 8];
			d_ch[c] = (a_ch[c] >= b_ch[c]) ? a_ch[c] - b_ch[c] : b_ch[c] - a_ch[c];
			sq_ch[c] = {8'd0, d_ch[c]} * {8'd0, d_ch[c]};
			sse_sum = sse_sum + ids_pkg::PIX_SSE_W'(sq_ch[c]);
			if (d_ch[c] > max_d) begin
				max_d = d_ch[c];
			end
			if (d_ch[c] > tolerance) begin
				chg = 1'b1;
			end
		end
	end

	assign pix_stall = q_full;
	assign push = pix_valid && !q_full;

	always_comb begin
		entry.actual = pix.actual_pixel;
		entry.baseline = pix.baseline_pixel;
		entry.last = pix.last_pixel;
		entry.changed = chg;
		entry.pix_max = max_d;
		entry.pix_sse = sse_sum;
	end

endmodule

`default_nettype wire

[hw/rtl/ids_fifo.sv]
// short queue of classified pixel pairs between front end and accumulator
// depends on ids_pkg
`default_nettype none

module ids_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire ids_pkg::cls_t push_entry,
	output logic               full,
	input  wire                pop,
	output logic               empty,
	output ids_pkg::cls_t      head
);

	ids_pkg::cls_t                slot_q [ids_pkg::QUEUE_DEPTH];
	logic [ids_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ids_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ids_pkg::QPTR_W:0]     cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full = (cnt_q == (ids_pkg::QPTR_W + 1)'(ids_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ids_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ids_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (ids_pkg::QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (ids_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ids_back.sv]
// back end: accumulates counts, largest delta and squared error, hashes one byte per cycle
// unless a final pixel waits on ids_final; depends on ids_pkg, takes from ids_fifo, feeds ids_final
`default_nettype none

module ids_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  wire ids_pkg::cls_t  q_head,
	output logic                q_pop,
	output logic                snap_valid,
	output ids_pkg::snap_t      snap,
	input  wire                 fin_ready
);

	ids_pkg::cls_t                  cur_q;
	logic                           cur_valid_q;
	logic [1:0]                     byte_q;
	logic [63:0]                    act_hash_q;
	logic [63:0]                    base_hash_q;
	logic [ids_pkg::COUNT_W-1:0]    changed_acc_q;
	logic [ids_pkg::COUNT_W-1:0]    pixel_acc_q;
	logic [7:0]                     max_delta_q;
	logic [ids_pkg::SSE_W-1:0]      sse_acc_q;

	logic                           step;
	logic                           done;
	logic                           load;
	logic [63:0]                    act_hash_nx;
	logic [63:0]                    base_hash_nx;
	logic [ids_pkg::SSE_W:0]        sse_sum;

	assign snap_valid = cur_valid_q && (byte_q == 2'd3) && cur_q.last;
	// the last byte of a final pixel waits until the result unit can take the totals
	assign step = cur_valid_q && !(snap_valid && !fin_ready);
	assign done = step && (byte_q == 2'd3);
	assign load = (!cur_valid_q || done) && !q_empty;
	assign q_pop = load;

	assign act_hash_nx = ids_pkg::fnv_step(act_hash_q, cur_q.actual[{byte_q, 3'b000} +: 8]);
	assign base_hash_nx = ids_pkg::fnv_step(base_hash_q, cur_q.baseline[{byte_q, 3'b000} +: 8]);
	assign sse_sum = {1'b0, sse_acc_q} + (ids_pkg::SSE_W + 1)'(cur_q.pix_sse);

	always_comb begin
		snap.changed_count = changed_acc_q;
		snap.total_count = pixel_acc_q;
		snap.largest_delta = max_delta_q;
		snap.sse = sse_acc_q;
		snap.actual_digest = act_hash_nx;
		snap.baseline_digest = base_hash_nx;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			byte_q <= '0;
			act_hash_q <= ids_pkg::FNV_BASIS;
			base_hash_q <= ids_pkg::FNV_BASIS;
			changed_acc_q <= '0;
			pixel_acc_q <= '0;
			max_delta_q <= '0;
			sse_acc_q <= '0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
			if (step) begin
				byte_q <= byte_q + 2'd1;
				act_hash_q <= act_hash_nx;
				base_hash_q <= base_hash_nx;
				if (byte_q == 2'd0) begin
					pixel_acc_q <= ids_pkg::sat_inc(pixel_acc_q);
					if (cur_q.changed) begin
						changed_acc_q <= ids_pkg::sat_inc(changed_acc_q);
					end
					if (cur_q.pix_max > max_delta_q) begin
						max_delta_q <= cur_q.pix_max;
					end
					sse_acc_q <= (sse_sum > {1'b0, ids_pkg::SSE_MAX}) ? ids_pkg::SSE_MAX
						: sse_sum[ids_pkg::SSE_W-1:0];
				end
				// totals leave with the final pixel, then a new image starts
				if (done && cur_q.last) begin
					act_hash_q <= ids_pkg::FNV_BASIS;
					base_hash_q <= ids_pkg::FNV_BASIS;
					changed_acc_q <= '0;
					pixel_acc_q <= '0;
					max_delta_q <= '0;
					sse_acc_q <= '0;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	a_clear_after_image: assert property (@(posedge clk) disable iff (!arst_n)
		(snap_valid && fin_ready) |=> (pixel_acc_q == '0 && sse_acc_q == '0
			&& act_hash_q == ids_pkg::FNV_BASIS))
		else $error("accumulators not cleared after image");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		(changed_acc_q <= pixel_acc_q) && (pixel_acc_q <= ids_pkg::COUNT_MAX))
		else $error("pixel counters out of order");
`endif

endmodule

`default_nettype wire

[hw/rtl/ids_final.sv]
// result unit: exact integer limit checks on image totals and the result register
// depends on ids_pkg; fed by ids_back
`default_nettype none

module ids_final (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire ids_pkg::cfg_t  cfg,
	input  wire                 snap_valid,
	input  wire ids_pkg::snap_t snap,
	output logic                fin_ready,
	output logic                res_valid,
	output ids_pkg::res_t       res,
	input  wire                 res_stall
);

	typedef enum logic [3:0] {
		FIN_IDLE = 4'b0001,
		FIN_MUL  = 4'b0010,
		FIN_PROD = 4'b0100,
		FIN_CMP  = 4'b1000
	} fin_state_t;

	fin_state_t                  state_q;
	ids_pkg::snap_t              snap_q;
	logic [31:0]                 rsq_s1;
	logic [41:0]                 fprod_s1;
	logic [58:0]                 rhs_s2;
	ids_pkg::res_t               res_q;
	logic                        res_valid_q;

	logic                        out_free;
	logic [26:0]                 n4;
	logic                        frac_ok;
	logic                        rmse_ok;

	assign fin_ready = (state_q == FIN_IDLE);
	assign out_free = !res_valid_q || !res_stall;
	assign n4 = {snap_q.total_count, 2'b00};
	assign frac_ok = {1'b0, snap_q.changed_count, 16'd0} <= fprod_s1;
	assign rmse_ok = {1'b0, snap_q.sse, 16'd0} <= rhs_s2;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (snap_valid && fin_ready) begin
			snap_q <= snap;
		end
		if (state_q == FIN_MUL) begin
			rsq_s1 <= 32'(cfg.rmse) * 32'(cfg.rmse);
			fprod_s1 <= 42'(cfg.fraction) * 42'(snap_q.total_count);
		end
		if (state_q == FIN_PROD) begin
			rhs_s2 <= 59'(rsq_s1) * 59'(n4);
		end
		if (state_q == FIN_CMP && out_free) begin
			res_q.passed <= frac_ok && rmse_ok;
			res_q.changed_count <= snap_q.changed_count;
			res_q.total_count <= snap_q.total_count;
			res_q.largest_delta <= snap_q.largest_delta;
			res_q.squared_error_sum <= snap_q.sse;
			res_q.actual_digest <= snap_q.actual_digest;
			res_q.baseline_digest <= snap_q.baseline_digest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FIN_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				FIN_IDLE: begin
					if (snap_valid) begin
						state_q <= FIN_MUL;
					end
				end
				FIN_MUL: begin
					state_q <= FIN_PROD;
				end
				FIN_PROD: begin
					state_q <= FIN_CMP;
				end
				FIN_CMP: begin
					if (out_free) begin
						state_q <= FIN_IDLE;
					end
				end
				default: begin
					state_q <= FIN_IDLE;
				end
			endcase
			if (state_q == FIN_CMP && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FIN_CMP && out_free) |=> (res_valid && state_q == FIN_IDLE))
		else $error("result not loaded after compare");
`endif

endmodule

`default_nettype wire

[dv/image_diff_statistics_top_tb.sv]
// self-checking testbench for image_diff_statistics_top: streams pixel pairs, checks image reports
// against a behavioral predictor kept in this file; depends on ids_pkg and the block's rtl
`timescale 1ns / 1ps

module image_diff_statistics_top_tb;

	localparam logic [63:0] FNV_PRIME = 64'h100000001b3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_PHASE = 4;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		ids_pkg::pix_t px;
		logic          pinned;
		ids_pkg::res_t want;
	} row_t;

	// under reset limits nothing passes once any channel differs
	localparam row_t DIRECTED_ROWS [14] = '{
		'{'{32'h00000000, 32'h00000000, 1'b1}, 1'b1,
			'{1'b1, 25'd0, 25'd1, 8'd0, 42'd0, 64'd0, 64'd0}},
		'{'{32'hffffffff, 32'h00000000, 1'b1}, 1'b1,
			'{1'b0, 25'd1, 25'd1, 8'd255, 42'd260100, 64'd0, 64'd0}},
		'{'{32'h00000000, 32'hffffffff, 1'b1}, 1'b1,
			'{1'b0, 25'd1, 25'd1, 8'd255, 42'd260100, 64'd0, 64'd0}},
		'{'{32'h12345678, 32'h12345678, 1'b0}, 1'b0, '0},
		'{'{32'h80808080, 32'h7f7f7f7f, 1'b1}, 1'b1,
			'{1'b0, 25'd1, 25'd2, 8'd1, 42'd4, 64'd0, 64'd0}},
		'{'{32'h000000ff, 32'h00000000, 1'b0}, 1'b0, '0},
		'{'{32'h0000ff00, 32'h00000000, 1'b0}, 1'b0, '0},
		'{'{32'h00ff0000, 32'h00000000, 1'b0}, 1'b0, '0},
		'{'{32'hff000000, 32'h00000000, 1'b1}, 1'b1,
			'{1'b0, 25'd4, 25'd4, 8'd255, 42'd260100, 64'd0, 64'd0}},
		'{'{32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0}, 1'b0, '0},
		'{'{32'hdeadbeef, 32'h01234567, 1'b0}, 1'b0, '0},
		'{'{32'h0f0f0f0f, 32'hf0f0f0f0, 1'b1}, 1'b0, '0},
		'{'{32'h55aa55aa, 32'h55aa55aa, 1'b1}, 1'b1,
			'{1'b1, 25'd0, 25'd1, 8'd0, 42'd0, 64'd0, 64'd0}},
		'{'{32'hfedcba98, 32'h76543210, 1'b1}, 1'b0, '0}
	};

	// tolerance, changed fraction, rmse; the all-ones row puts both limits above range
	localparam logic [31:0] LIMIT_TABLE [5][3] = '{
		'{32'd0, 32'd0, 32'd0},
		'{32'd255, 32'd65536, 32'd65280},
		'{32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'd4, 32'd32768, 32'd256},
		'{32'd16, 32'd6554, 32'd2560}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	ids_pkg::pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ids_pkg::res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ids_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// limits as programmed
	logic [7:0] lim_tolerance = '0;
	logic [16:0] lim_fraction = '0;
	logic [15:0] lim_rmse = '0;

	// running totals of the image in flight
	logic [63:0] acc_actual_hash = ids_pkg::FNV_BASIS;
	logic [63:0] acc_baseline_hash = ids_pkg::FNV_BASIS;
	logic [ids_pkg::COUNT_W-1:0] acc_changed = '0;
	logic [ids_pkg::COUNT_W-1:0] acc_pixels = '0;
	logic [7:0] acc_max_delta = '0;
	logic [ids_pkg::SSE_W:0] acc_sse = '0;

	ids_pkg::res_t pending_reports[$];
	int mismatch_count = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	image_diff_statistics_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] fnv_word(input logic [63:0] h, input logic [31:0] w);
		for (int i = 0; i < 4; i++) begin
			h = (h ^ {56'd0, w[8*i +: 8]}) * FNV_PRIME;
		end
		return h;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// folds one accepted pixel pair into the image totals; the last pixel yields a report
	task automatic tally_pixel(input ids_pkg::pix_t p);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] d;
		logic [17:0] pix_sq;
		logic [ids_pkg::SSE_W:0] sse_next;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic changed;
		logic frac_ok;
		ids_pkg::res_t r;
		changed = 1'b0;
		pix_sq = '0;
		for (int c = 0; c < 4; c++) begin
			a = p.actual_pixel[8*c +: 8];
			b = p.baseline_pixel[8*c +: 8];
			d = (a >= b) ? a - b : b - a;
			if (d > acc_max_delta) acc_max_delta = d;
			if (d > lim_tolerance) changed = 1'b1;
			pix_sq = pix_sq + {10'd0, d} * {10'd0, d};
		end
		acc_actual_hash = fnv_word(acc_actual_hash, p.actual_pixel);
		acc_baseline_hash = fnv_word(acc_baseline_hash, p.baseline_pixel);
		sse_next = acc_sse + (ids_pkg::SSE_W + 1)'(pix_sq);
		acc_sse = (sse_next > {1'b0, ids_pkg::SSE_MAX}) ? {1'b0, ids_pkg::SSE_MAX} : sse_next;
		acc_pixels = (acc_pixels < ids_pkg::COUNT_MAX) ? acc_pixels + ids_pkg::COUNT_W'(1)
			: ids_pkg::COUNT_MAX;
		if (changed)
			acc_changed = (acc_changed < ids_pkg::COUNT_MAX)
				? acc_changed + ids_pkg::COUNT_W'(1) : ids_pkg::COUNT_MAX;
		if (p.last_pixel) begin
			lhs = 128'(acc_changed) << 16;
			rhs = 128'(lim_fraction) * 128'(acc_pixels);
			frac_ok = (lhs <= rhs);
			lhs = 128'(acc_sse) << 16;
			rhs = 128'(lim_rmse) * 128'(lim_rmse) * 128'(acc_pixels) * 128'd4;
			r.passed = frac_ok && (lhs <= rhs);
			r.changed_count = acc_changed;
			r.total_count = acc_pixels;
			r.largest_delta = acc_max_delta;
			r.squared_error_sum = acc_sse[ids_pkg::SSE_W-1:0];
			r.actual_digest = acc_actual_hash;
			r.baseline_digest = acc_baseline_hash;
			pending_reports.push_back(r);
			acc_actual_hash = ids_pkg::FNV_BASIS;
			acc_baseline_hash = ids_pkg::FNV_BASIS;
			acc_changed = '0;
			acc_pixels = '0;
			acc_max_delta = '0;
			acc_sse = '0;
		end
	endtask

	// offers one pixel pair, waits for the transaction, then maybe takes a break
	task automatic drive_pixel(input ids_pkg::pix_t p);
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		tally_pixel(p);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] data,
			output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [31:0] tol, input logic [31:0] frac, input logic [31:0] rmse);
		logic [31:0] rd;
		apb_xfer(1'b1, ids_pkg::REG_TOLERANCE, tol, rd);
		lim_tolerance = tol[7:0];
		apb_xfer(1'b1, ids_pkg::REG_FRACTION, frac, rd);
		lim_fraction = frac[16:0];
		apb_xfer(1'b1, ids_pkg::REG_RMSE, rmse, rd);
		lim_rmse = rmse[15:0];
		// nothing lives at this address, the limits must survive the write
		apb_xfer(1'b1, REG_UNUSED, $urandom, rd);
		apb_xfer(1'b0, ids_pkg::REG_TOLERANCE, '0, rd);
		check_field("tolerance readback", lim_tolerance, rd);
		apb_xfer(1'b0, ids_pkg::REG_FRACTION, '0, rd);
		check_field("fraction readback", lim_fraction, rd);
		apb_xfer(1'b0, ids_pkg::REG_RMSE, '0, rd);
		check_field("rmse readback", lim_rmse, rd);
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 20000 && pending_reports.size() != 0; k++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d image reports never arrived", pending_reports.size());
			mismatch_count++;
			pending_reports.delete();
		end
	endtask

	// noise_pct picks fully random pairs, the rest are identical or slightly perturbed
	function automatic ids_pkg::pix_t random_pair(input int noise_pct, input int spread);
		ids_pkg::pix_t p;
		p.baseline_pixel = $urandom;
		p.actual_pixel = p.baseline_pixel;
		p.last_pixel = 1'b0;
		if ($urandom_range(0, 99) < noise_pct) begin
			p.actual_pixel = $urandom;
		end else if ($urandom_range(0, 2) != 0) begin
			for (int c = 0; c < 4; c++) begin
				p.actual_pixel[8*c +: 8] = p.baseline_pixel[8*c +: 8]
					+ 8'($urandom_range(0, 2 * spread)) - 8'(spread);
			end
		end
		return p;
	endfunction

	task automatic run_images(input int target);
		int sent;
		int len;
		int noise_pct;
		int spread;
		ids_pkg::pix_t p;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: noise_pct = 0;
				1: noise_pct = 10;
				default: noise_pct = 40;
			endcase
			spread = $urandom_range(0, 4);
			for (int i = 0; i < len; i++) begin
				p = random_pair(noise_pct, spread);
				p.last_pixel = (i == len - 1);
				drive_pixel(p);
			end
			sent += len;
		end
	endtask

	// result side: stall pattern of its own, plus one long hold-off on request
	initial begin : result_sink
		int span;
		int pct;
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				span = $urandom_range(10, 60);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 30;
					2: pct = 70;
					default: pct = 95;
				endcase
				repeat (span) begin
					res_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_reports
		ids_pkg::res_t want;
		if (res_valid && !res_stall) begin
			if (pending_reports.size() == 0) begin
				$error("image report with no image pending");
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("passed", want.passed, res.passed);
				check_field("changed_count", want.changed_count, res.changed_count);
				check_field("total_count", want.total_count, res.total_count);
				check_field("largest_delta", want.largest_delta, res.largest_delta);
				check_field("squared_error_sum", want.squared_error_sum, res.squared_error_sum);
				check_field("actual_digest", want.actual_digest, res.actual_digest);
				check_field("baseline_digest", want.baseline_digest, res.baseline_digest);
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		ids_pkg::res_t r;
		int tail;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass under reset limits
		foreach (DIRECTED_ROWS[i]) begin
			drive_pixel(DIRECTED_ROWS[i].px);
			if (DIRECTED_ROWS[i].pinned) begin
				tail = pending_reports.size() - 1;
				r = pending_reports[tail];
				r.passed = DIRECTED_ROWS[i].want.passed;
				r.changed_count = DIRECTED_ROWS[i].want.changed_count;
				r.total_count = DIRECTED_ROWS[i].want.total_count;
				r.largest_delta = DIRECTED_ROWS[i].want.largest_delta;
				r.squared_error_sum = DIRECTED_ROWS[i].want.squared_error_sum;
				pending_reports[tail] = r;
			end
		end
		drain_results();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < 5)
				set_limits(LIMIT_TABLE[ph][0], LIMIT_TABLE[ph][1], LIMIT_TABLE[ph][2]);
			else
				set_limits($urandom, $urandom, $urandom);
			// result side holds off while short images keep coming, so the input backs up
			if (ph == HOLD_PHASE) hold_req = 1'b1;
			run_images(PHASE_ITEMS);
			drain_results();
		end

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
